### design/spo_pkg.sv
// Package for the slot pool with oldest-first eviction.
// Holds the controller states, datapath operation codes and the command and status structs.
// No dependencies.
`default_nettype none

package spo_pkg;

    localparam int SLOTS_DEFAULT = 512;
    localparam int SLOT_W        = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_CHECK,
        S_REL_FREE,
        S_EV_UNLINK,
        S_EV_FREE,
        S_ALLOC_READ,
        S_ALLOC_LINK,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REL_READ,
        OP_EVICT_READ,
        OP_ALLOC_READ,
        OP_UNLINK,
        OP_REFUSE,
        OP_FREE,
        OP_ALLOC_LINK
    } t_op;

    typedef struct packed {
        logic cap;
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic free_empty;
        logic oldest_null;
        logic act;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### design/spo_ctrl.sv
// Controller state machine of the slot pool.
// Sequences the link memory reads and writes of each command; uses spo_pkg.
`default_nettype none

module spo_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_command,
    input  spo_pkg::t_stat     i_stat,
    output logic               o_ready,
    output spo_pkg::t_cmd      o_cmd
);

    spo_pkg::t_state r_state;
    spo_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_cmd.cap       = 1'b0;
        o_cmd.op        = spo_pkg::OP_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            spo_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_command) begin
                        o_cmd.op = spo_pkg::OP_REL_READ;
                        n_state  = spo_pkg::S_REL_CHECK;
                    end else if (!i_stat.free_empty) begin
                        o_cmd.op = spo_pkg::OP_ALLOC_READ;
                        n_state  = spo_pkg::S_ALLOC_LINK;
                    end else if (!i_stat.oldest_null) begin
                        o_cmd.op = spo_pkg::OP_EVICT_READ;
                        n_state  = spo_pkg::S_EV_UNLINK;
                    end else begin
                        n_state  = spo_pkg::S_DONE;
                    end
                end
            end
            spo_pkg::S_REL_CHECK: begin
                if (i_stat.act) begin
                    o_cmd.op = spo_pkg::OP_UNLINK;
                    n_state  = spo_pkg::S_REL_FREE;
                end else begin
                    o_cmd.op = spo_pkg::OP_REFUSE;
                    n_state  = spo_pkg::S_DONE;
                end
            end
            spo_pkg::S_REL_FREE: begin
                o_cmd.op = spo_pkg::OP_FREE;
                n_state  = spo_pkg::S_DONE;
            end
            spo_pkg::S_EV_UNLINK: begin
                o_cmd.op = spo_pkg::OP_UNLINK;
                n_state  = spo_pkg::S_EV_FREE;
            end
            spo_pkg::S_EV_FREE: begin
                o_cmd.op = spo_pkg::OP_FREE;
                n_state  = spo_pkg::S_ALLOC_READ;
            end
            spo_pkg::S_ALLOC_READ: begin
                o_cmd.op = spo_pkg::OP_ALLOC_READ;
                n_state  = spo_pkg::S_ALLOC_LINK;
            end
            spo_pkg::S_ALLOC_LINK: begin
                o_cmd.op = spo_pkg::OP_ALLOC_LINK;
                n_state  = spo_pkg::S_DONE;
            end
            spo_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = spo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spo_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/spo_datapath.sv
// Datapath of the slot pool: next and previous link memories, list head registers,
// fill count and the result register. Driven by commands from spo_ctrl; uses spo_pkg.
`default_nettype none

module spo_datapath #(
    parameter int SLOTS = spo_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  spo_pkg::t_cmd                    i_cmd,
    input  wire logic                        i_command,
    input  wire logic [spo_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic                        i_out_ready,
    output spo_pkg::t_stat                   o_stat,
    output logic                             o_valid,
    output logic [spo_pkg::SLOT_W-1:0]       o_granted_slot,
    output logic                             o_evicted,
    output logic [spo_pkg::SLOT_W-1:0]       o_evicted_slot,
    output logic                             o_status
);

    localparam int LW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = (LW > spo_pkg::SLOT_W) ? LW : spo_pkg::SLOT_W;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    logic [LW-1:0] r_next_mem [SLOTS];
    logic [LW:0]   r_prev_mem [SLOTS];
    logic [LW-1:0] r_n_rd;
    logic [LW:0]   r_p_rd;

    logic [LW-1:0] r_free_head;
    logic [LW-1:0] r_newest;
    logic [LW-1:0] r_oldest;
    logic [LW-1:0] r_fill;
    logic          r_out_valid;

    logic [LW-1:0]              r_tgt;
    logic                       r_in_range;
    logic                       r_virgin;
    logic [spo_pkg::SLOT_W-1:0] r_granted;
    logic                       r_ev;
    logic [spo_pkg::SLOT_W-1:0] r_ev_slot;
    logic                       r_status;
    logic [spo_pkg::SLOT_W-1:0] r_o_granted;
    logic                       r_o_ev;
    logic [spo_pkg::SLOT_W-1:0] r_o_ev_slot;
    logic                       r_o_status;

    logic          slot_ok;
    logic          ev_rd;
    logic [LW-1:0] rd_prev;
    logic [LW-1:0] fh_inc;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          nw_en;
    logic [IW-1:0] nw_addr;
    logic [LW-1:0] nw_data;
    logic          pw_en;
    logic [IW-1:0] pw_addr;
    logic [LW:0]   pw_data;

    // Slots at or above the fill count have never been handed out.
    assign slot_ok = CW'(i_slot) < CW'(r_fill);
    assign ev_rd   = (i_cmd.op == spo_pkg::OP_EVICT_READ);
    assign rd_prev = r_p_rd[LW-1:0];
    assign fh_inc  = LW'(r_free_head + 1'b1);

    assign o_stat.free_empty  = (r_free_head == NIL);
    assign o_stat.oldest_null = (r_oldest == NIL);
    assign o_stat.act         = r_in_range & r_p_rd[LW];
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        nw_en   = 1'b0;
        nw_addr = '0;
        nw_data = '0;
        pw_en   = 1'b0;
        pw_addr = '0;
        pw_data = '0;
        case (i_cmd.op)
            spo_pkg::OP_REL_READ: begin
                rd_en   = 1'b1;
                rd_addr = slot_ok ? IW'(i_slot) : '0;
            end
            spo_pkg::OP_EVICT_READ: begin
                rd_en   = 1'b1;
                rd_addr = IW'(r_oldest);
            end
            spo_pkg::OP_ALLOC_READ: begin
                rd_en   = 1'b1;
                rd_addr = IW'(r_free_head);
                if (r_newest != NIL) begin
                    pw_en   = 1'b1;
                    pw_addr = IW'(r_newest);
                    pw_data = {1'b1, r_free_head};
                end
            end
            spo_pkg::OP_UNLINK: begin
                if (rd_prev != NIL) begin
                    nw_en   = 1'b1;
                    nw_addr = IW'(rd_prev);
                    nw_data = r_n_rd;
                end
                if (r_n_rd != NIL) begin
                    pw_en   = 1'b1;
                    pw_addr = IW'(r_n_rd);
                    pw_data = {1'b1, rd_prev};
                end
            end
            spo_pkg::OP_FREE: begin
                nw_en   = 1'b1;
                nw_addr = IW'(r_tgt);
                nw_data = r_free_head;
                pw_en   = 1'b1;
                pw_addr = IW'(r_tgt);
                pw_data = {1'b0, NIL};
            end
            spo_pkg::OP_ALLOC_LINK: begin
                nw_en   = 1'b1;
                nw_addr = IW'(r_free_head);
                nw_data = r_newest;
                pw_en   = 1'b1;
                pw_addr = IW'(r_free_head);
                pw_data = {1'b1, NIL};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nw_en) begin
            r_next_mem[nw_addr] <= nw_data;
        end
        if (rd_en) begin
            r_n_rd <= r_next_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_prev_mem[pw_addr] <= pw_data;
        end
        if (rd_en) begin
            r_p_rd <= r_prev_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_newest    <= NIL;
            r_oldest    <= NIL;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                spo_pkg::OP_ALLOC_READ: begin
                    if (r_newest == NIL) begin
                        r_oldest <= r_free_head;
                    end
                end
                spo_pkg::OP_UNLINK: begin
                    if (rd_prev == NIL) begin
                        r_newest <= r_n_rd;
                    end
                    if (r_n_rd == NIL) begin
                        r_oldest <= rd_prev;
                    end
                end
                spo_pkg::OP_FREE: begin
                    r_free_head <= r_tgt;
                end
                spo_pkg::OP_ALLOC_LINK: begin
                    r_newest    <= r_free_head;
                    r_free_head <= r_virgin ? fh_inc : r_n_rd;
                    if (r_virgin) begin
                        r_fill <= fh_inc;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_granted  <= i_command ? i_slot : '0;
            r_ev       <= ev_rd;
            r_ev_slot  <= ev_rd ? spo_pkg::SLOT_W'(r_oldest) : '0;
            r_status   <= 1'b0;
            r_in_range <= slot_ok;
            r_tgt      <= ev_rd ? r_oldest : LW'(i_slot);
        end
        case (i_cmd.op)
            spo_pkg::OP_ALLOC_READ: begin
                r_virgin <= (r_free_head >= r_fill);
            end
            spo_pkg::OP_REFUSE: begin
                r_status <= 1'b1;
            end
            spo_pkg::OP_ALLOC_LINK: begin
                r_granted <= spo_pkg::SLOT_W'(r_free_head);
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_o_granted <= r_granted;
            r_o_ev      <= r_ev;
            r_o_ev_slot <= r_ev_slot;
            r_o_status  <= r_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_granted_slot = r_o_granted;
    assign o_evicted      = r_o_ev;
    assign o_evicted_slot = r_o_ev_slot;
    assign o_status       = r_o_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NIL)
        else $error("fill count beyond pool size");

    a_free_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == spo_pkg::OP_FREE) |=> (r_free_head != NIL))
        else $error("free list empty after a slot was freed");

    a_link_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == spo_pkg::OP_ALLOC_LINK) |-> (r_free_head != NIL))
        else $error("allocation linked with an empty free list");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

### design/slot_pool_with_oldest_eviction_top.sv
// Top level of the slot pool with oldest-first eviction.
// Instantiates spo_ctrl and spo_datapath; uses spo_pkg.
//
// Each item is one command, allocate or release, and gives exactly one result item. The
// block takes one item at a time: after acceptance an allocate passes ALLOC_LINK, a release
// REL_CHECK and REL_FREE, a refused release REL_CHECK and an evicting allocate EV_UNLINK,
// EV_FREE, ALLOC_READ and ALLOC_LINK, then DONE loads the result register once it is free
// and the block is ready again while the result waits to be taken. These steps are set by
// the next and previous link memories, each of which gives one read and one write per cycle.
// No clearing pass runs after reset: a fill count marks the slots never handed out.
`default_nettype none

module slot_pool_with_oldest_eviction_top #(
    parameter int SLOTS = spo_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_command,
    input  wire logic [spo_pkg::SLOT_W-1:0]  i_slot,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [spo_pkg::SLOT_W-1:0]       o_granted_slot,
    output logic                             o_evicted,
    output logic [spo_pkg::SLOT_W-1:0]       o_evicted_slot,
    output logic                             o_status
);

    spo_pkg::t_cmd  cmd;
    spo_pkg::t_stat stat;

    spo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (stat),
        .o_ready   (o_ready),
        .o_cmd     (cmd)
    );

    spo_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_command),
        .i_slot         (i_slot),
        .i_out_ready    (i_ready),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_granted_slot (o_granted_slot),
        .o_evicted      (o_evicted),
        .o_evicted_slot (o_evicted_slot),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire
